// ----- rtl/core/sacl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

  // Default geometry
  localparam int DEF_SETS      = 64;
  localparam int DEF_WAYS      = 4;
  localparam int DEF_ADDR_BITS = 48;

  // Word field widths
  localparam int ADDRESS_W = 48;
  localparam int COUNT_W   = 32;
  localparam int STAMP_W   = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX  = 2'd2;

  localparam int OFFSET_W = 4;
  localparam int INDEX_W  = 3;

  localparam logic [OFFSET_W-1:0] OFFSET_RST = 4'd6;
  localparam logic [INDEX_W-1:0]  INDEX_RST  = 3'd6;

  // Replacement policy codes
  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  // Access kind codes
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Per-set insert counter value after reset
  localparam logic [STAMP_W-1:0] CTR_RST = 32'd1;

endpackage

`default_nettype wire

// ----- rtl/core/sacl_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sacl_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [sacl_pkg::ADDRESS_W-1:0] address;

  modport source (output valid, output mode, output address, input ready);
  modport sink   (input valid, input mode, input address, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sacl_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sacl_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         mem_read;
  logic                         mem_write;
  logic [sacl_pkg::COUNT_W-1:0] hit_total;
  logic [sacl_pkg::COUNT_W-1:0] miss_total;
  logic [sacl_pkg::COUNT_W-1:0] read_total;
  logic [sacl_pkg::COUNT_W-1:0] write_total;

  modport source (output valid, output hit, output mem_read, output mem_write,
                  output hit_total, output miss_total, output read_total,
                  output write_total, input ready);
  modport sink   (input valid, input hit, input mem_read, input mem_write,
                  input hit_total, input miss_total, input read_total,
                  input write_total, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sacl_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sacl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sacl_pkg::CFG_IDX_W-1:0]  index;
  logic [sacl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/set_assoc_cache_lookup.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Tag directory of a set-associative, write-through, write-allocate cache.
// Each input word (mode, address) is looked up in one set; the result word
// reports hit, memory read (every miss fills a block) and memory write (every
// write goes through), plus running 32-bit totals after this access. Victims
// are least recently used or first inserted, per the policy register. Throughput
// is one access per clock while results are taken; the result word is registered
// and, while it waits, holds the lookup stage and the input. An accepted word's
// address is split and the set's row (valid bits, tags, recency ranks, insert
// stamps and set counter) registered from a memory with one read and one write
// port; the lookup stage compares all ways, picks the way, updates the row and
// writes it back. An access to the same set as the one just ahead of it takes the
// freshly built row from a bypass register instead of the memory. A per-set
// "touched" flop makes rows read as their reset contents until first written, so
// there is no clearing pass after reset. Configure only while the block is idle.
module set_assoc_cache_lookup #(
  parameter int SETS      = sacl_pkg::DEF_SETS,
  parameter int WAYS      = sacl_pkg::DEF_WAYS,
  parameter int ADDR_BITS = sacl_pkg::DEF_ADDR_BITS
) (
  input  wire           clk,
  input  wire           rst_n,
  sacl_in_if.sink       in_ch,
  sacl_out_if.source    out_ch,
  sacl_cfg_if.sink      cfg_ch
);

  // Geometry
  localparam int MIB      = $clog2(SETS + 1) - 1;             // sets in use: 2^MIB
  localparam int IDX_W    = (MIB > 0) ? MIB : 1;
  localparam int SET_ROWS = 1 << MIB;
  localparam int TAG_W    = (ADDR_BITS < sacl_pkg::ADDRESS_W) ? ADDR_BITS
                                                               : sacl_pkg::ADDRESS_W;
  localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_W    = RANK_W;
  localparam int CW       = sacl_pkg::COUNT_W;
  localparam int SW       = sacl_pkg::STAMP_W;

  localparam logic [3:0]        MIB_V     = 4'(MIB);
  localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(WAYS - 1);

  typedef struct packed {
    logic [WAYS-1:0]             vld;
    logic [WAYS-1:0][TAG_W-1:0]  tag;
    logic [WAYS-1:0][RANK_W-1:0] rank;
    logic [WAYS-1:0][SW-1:0]     stamp;
    logic [SW-1:0]               ctr;
  } row_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                         policy_r;
  logic [sacl_pkg::OFFSET_W-1:0] offset_r;
  logic [sacl_pkg::INDEX_W-1:0]  index_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= sacl_pkg::POLICY_LRU;
      offset_r <= sacl_pkg::OFFSET_RST;
      index_r  <= sacl_pkg::INDEX_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        sacl_pkg::CFG_POLICY: policy_r <= cfg_ch.data[0];
        sacl_pkg::CFG_OFFSET: offset_r <= cfg_ch.data[sacl_pkg::OFFSET_W-1:0];
        sacl_pkg::CFG_INDEX:  index_r  <= cfg_ch.data[sacl_pkg::INDEX_W-1:0];
        default: ;                                            // unmapped index
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Address split (input side)
  // ---------------------------------------------------------------------------
  logic [3:0]       ib_eff;
  logic [4:0]       tag_sh;
  logic [TAG_W-1:0] addr_m;
  logic [TAG_W-1:0] addr_sh;
  logic [IDX_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;

  always_comb begin
    // index bit count clamps to the number of sets built
    ib_eff  = ({1'b0, index_r} > MIB_V) ? MIB_V : {1'b0, index_r};
    addr_m  = in_ch.address[TAG_W-1:0];
    addr_sh = addr_m >> offset_r;
    in_set  = addr_sh[IDX_W-1:0] & ~({IDX_W{1'b1}} << ib_eff);
    tag_sh  = {1'b0, offset_r} + {1'b0, ib_eff};
    in_tag  = addr_m >> tag_sh;
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------------
  logic s1_v_r;
  logic out_v_r;
  logic s1_fire;
  logic in_acc;

  assign s1_fire     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_fire;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Lookup stage registers
  logic             s1_mode_r;
  logic [IDX_W-1:0] s1_set_r;
  logic [TAG_W-1:0] s1_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= in_ch.mode;
      s1_set_r  <= in_set;
      s1_tag_r  <= in_tag;
    end
  end

  // ---------------------------------------------------------------------------
  // Set memory, touched flops and same-set bypass
  // ---------------------------------------------------------------------------
  row_t                mem_r [SET_ROWS];
  row_t                rd_row_r;
  logic                rd_touched_r;
  logic [SET_ROWS-1:0] touched_r;
  logic                fwd_r;
  row_t                fwd_row_r;
  row_t                row_nxt;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row_r <= mem_r[in_set];
    end
    if (s1_fire) begin
      mem_r[s1_set_r] <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touched_r <= '0;
      fwd_r     <= 1'b0;
    end else begin
      if (s1_fire) begin
        touched_r[s1_set_r] <= 1'b1;
      end
      if (in_acc) begin
        fwd_r <= s1_fire && (in_set == s1_set_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_touched_r <= touched_r[in_set];
      fwd_row_r    <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup, replacement and row update
  // ---------------------------------------------------------------------------
  row_t              rst_row;
  row_t              row_cur;
  logic              hit_f;
  logic [WAY_W-1:0]  hit_w;
  logic              vac_f;
  logic [WAY_W-1:0]  vac_w;
  logic [WAY_W-1:0]  lru_w;
  logic [WAY_W-1:0]  fifo_w;
  logic [WAY_W-1:0]  pick;
  logic [RANK_W-1:0] pick_rank;
  logic [CW-1:0]     hit_cnt_r, miss_cnt_r, read_cnt_r, write_cnt_r;
  logic [CW-1:0]     hit_cnt_nxt, miss_cnt_nxt, read_cnt_nxt, write_cnt_nxt;

  always_comb begin
    rst_row     = '0;
    rst_row.ctr = sacl_pkg::CTR_RST;
    for (int w = 0; w < WAYS; w++) begin
      rst_row.rank[w] = RANK_W'(w);
    end

    if (fwd_r) begin
      row_cur = fwd_row_r;
    end else if (rd_touched_r) begin
      row_cur = rd_row_r;
    end else begin
      row_cur = rst_row;
    end

    // first valid way with a matching tag
    hit_f = 1'b0;
    hit_w = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_f && row_cur.vld[w] && (row_cur.tag[w] == s1_tag_r)) begin
        hit_f = 1'b1;
        hit_w = WAY_W'(w);
      end
    end

    // vacant way with the smallest rank
    vac_f = 1'b0;
    vac_w = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!row_cur.vld[w] && (!vac_f || (row_cur.rank[w] < row_cur.rank[vac_w]))) begin
        vac_f = 1'b1;
        vac_w = WAY_W'(w);
      end
    end

    // LRU victim: last way ranked oldest, way 0 if none
    lru_w = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row_cur.rank[w] == RANK_LAST) begin
        lru_w = WAY_W'(w);
      end
    end

    // FIFO victim: smallest stamp, ties to the more recent rank
    fifo_w = '0;
    for (int w = 1; w < WAYS; w++) begin
      if ((row_cur.stamp[w] < row_cur.stamp[fifo_w]) ||
          ((row_cur.stamp[w] == row_cur.stamp[fifo_w]) &&
           (row_cur.rank[w] < row_cur.rank[fifo_w]))) begin
        fifo_w = WAY_W'(w);
      end
    end

    if (hit_f) begin
      pick = hit_w;
    end else if (vac_f) begin
      pick = vac_w;
    end else if (policy_r == sacl_pkg::POLICY_FIFO) begin
      pick = fifo_w;
    end else begin
      pick = lru_w;
    end

    row_nxt = row_cur;
    if (!hit_f) begin
      row_nxt.vld[pick]   = 1'b1;
      row_nxt.tag[pick]   = s1_tag_r;
      row_nxt.stamp[pick] = row_cur.ctr;
      row_nxt.ctr         = row_cur.ctr + SW'(1);
    end

    // promote the picked way to most recent
    pick_rank = row_cur.rank[pick];
    for (int w = 0; w < WAYS; w++) begin
      if (row_cur.rank[w] < pick_rank) begin
        row_nxt.rank[w] = row_cur.rank[w] + RANK_W'(1);
      end
    end
    row_nxt.rank[pick] = '0;

    hit_cnt_nxt   = hit_cnt_r  + CW'(hit_f);
    miss_cnt_nxt  = miss_cnt_r + CW'(!hit_f);
    read_cnt_nxt  = read_cnt_r + CW'(!hit_f);
    write_cnt_nxt = write_cnt_r + CW'(s1_mode_r == sacl_pkg::MODE_WRITE);
  end

  // ---------------------------------------------------------------------------
  // Running totals
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      read_cnt_r  <= '0;
      write_cnt_r <= '0;
    end else if (s1_fire) begin
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      read_cnt_r  <= read_cnt_nxt;
      write_cnt_r <= write_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic          out_hit_r, out_rd_r, out_wr_r;
  logic [CW-1:0] out_hit_tot_r, out_miss_tot_r, out_rd_tot_r, out_wr_tot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_hit_r      <= hit_f;
      out_rd_r       <= !hit_f;
      out_wr_r       <= (s1_mode_r == sacl_pkg::MODE_WRITE);
      out_hit_tot_r  <= hit_cnt_nxt;
      out_miss_tot_r <= miss_cnt_nxt;
      out_rd_tot_r   <= read_cnt_nxt;
      out_wr_tot_r   <= write_cnt_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.mem_read    = out_rd_r;
  assign out_ch.mem_write   = out_wr_r;
  assign out_ch.hit_total   = out_hit_tot_r;
  assign out_ch.miss_total  = out_miss_tot_r;
  assign out_ch.read_total  = out_rd_tot_r;
  assign out_ch.write_total = out_wr_tot_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTH
  // every miss fetches exactly one block
  a_read_eq_miss: assert property (@(posedge clk) disable iff (!rst_n)
    read_cnt_r == miss_cnt_r)
    else $error("memory read total diverged from miss total");

  // each retired access is a hit or a miss, never both or neither
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (CW'(hit_cnt_r + miss_cnt_r) ==
                 CW'($past(hit_cnt_r + miss_cnt_r) + CW'(1))))
    else $error("hit plus miss total did not advance by one");

  // a reported result is either a hit or a fill
  a_hit_xor_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_hit_r != out_rd_r))
    else $error("result word flags hit and fill together");

  // bypass taken whenever the previous access retires into the same set
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_fire && (in_set == s1_set_r)) |=> (fwd_r && s1_v_r))
    else $error("same-set bypass missed");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import sacl_pkg::*;

  localparam int SETS    = DEF_SETS;
  localparam int WAYS    = DEF_WAYS;
  localparam int ADDR_W  = DEF_ADDR_BITS;
  localparam int LINES   = SETS * WAYS;
  // largest k with 2^k <= SETS; a larger index_bits setting is clamped to it
  localparam int MAX_IB  = $clog2(SETS + 1) - 1;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 4;

  // one result word as the block reports it
  typedef struct packed {
    logic               hit;
    logic               mem_read;
    logic               mem_write;
    logic [COUNT_W-1:0] hit_total;
    logic [COUNT_W-1:0] miss_total;
    logic [COUNT_W-1:0] read_total;
    logic [COUNT_W-1:0] write_total;
  } lookup_word_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sacl_in_if  in_ch ();
  sacl_out_if out_ch ();
  sacl_cfg_if cfg_ch ();

  set_assoc_cache_lookup dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Directory shadow: our own copy of the tag store and the settings.
  // ---------------------------------------------------------------------------
  logic                         cur_policy;
  logic [OFFSET_W-1:0]          cur_offset;
  logic [INDEX_W-1:0]           cur_index;

  bit                           line_valid [LINES];
  logic [ADDR_W-1:0]            line_tag   [LINES];
  int unsigned                  line_rank  [LINES];   // 0 = most recent
  logic [STAMP_W-1:0]           line_stamp [LINES];
  logic [STAMP_W-1:0]           set_ctr    [SETS];
  logic [COUNT_W-1:0]           n_hit, n_miss, n_read, n_write;

  lookup_word_t                 pending_q[$];         // expected result words
  int                           fail_count  = 0;
  int                           phase_count = 0;

  // sender pacing
  bit                           gaps_on     = 1'b1;
  int                           burst_left  = 0;

  // receiver hold-off requests: the test bumps hold_asked, the receiver serves
  int                           hold_asked  = 0;
  int                           hold_served = 0;
  int                           hold_left   = 0;
  int                           phase_left  = 0;
  int                           stall_pct   = 0;

  lookup_word_t                 want_word, seen_word;

  function automatic void clear_directory();
    int unsigned s, w;
    cur_policy = POLICY_LRU;
    cur_offset = OFFSET_RST;
    cur_index  = INDEX_RST;
    for (s = 0; s < SETS; s++) begin
      for (w = 0; w < WAYS; w++) begin
        line_valid[s*WAYS+w] = 1'b0;
        line_tag[s*WAYS+w]   = '0;
        line_rank[s*WAYS+w]  = w;
        line_stamp[s*WAYS+w] = '0;
      end
      set_ctr[s] = CTR_RST;
    end
    n_hit   = '0;
    n_miss  = '0;
    n_read  = '0;
    n_write = '0;
  endfunction

  function automatic int unsigned eff_index_bits();
    return (cur_index > MAX_IB) ? MAX_IB : cur_index;
  endfunction

  // move way w of the set at base to the front of the recency order
  function automatic void make_recent(int unsigned base, int unsigned w);
    int unsigned r, i;
    r = line_rank[base+w];
    for (i = 0; i < WAYS; i++)
      if (line_rank[base+i] < r) line_rank[base+i]++;
    line_rank[base+w] = 0;
  endfunction

  // look one access up in the shadow directory, update it, return the word
  function automatic lookup_word_t lookup_access(logic wr, logic [ADDR_W-1:0] addr);
    lookup_word_t      res;
    int unsigned       ib, set_no, base, pick, w;
    logic [ADDR_W-1:0] tg, set_bits;
    ib       = eff_index_bits();
    set_bits = (addr >> cur_offset) & ((ADDR_W'(1) << ib) - 1);
    set_no   = set_bits[31:0];
    tg       = addr >> (cur_offset + ib);
    base     = set_no * WAYS;
    pick     = WAYS;
    // tags only count on valid ways
    for (w = 0; w < WAYS; w++)
      if (pick == WAYS && line_valid[base+w] && line_tag[base+w] == tg) pick = w;
    if (pick < WAYS) begin
      res.hit = 1'b1;
      n_hit++;
      make_recent(base, pick);
    end else begin
      res.hit = 1'b0;
      n_miss++;
      n_read++;
      // vacant way with the lowest rank first
      for (w = 0; w < WAYS; w++)
        if (!line_valid[base+w] &&
            (pick == WAYS || line_rank[base+w] < line_rank[base+pick]))
          pick = w;
      if (pick == WAYS) begin
        if (cur_policy == POLICY_LRU) begin
          for (w = 0; w < WAYS; w++)
            if (line_rank[base+w] == WAYS - 1) pick = w;
          if (pick == WAYS) pick = 0;
        end else begin
          // oldest stamp wins, ties go to the more recent way
          pick = 0;
          for (w = 1; w < WAYS; w++)
            if (line_stamp[base+w] < line_stamp[base+pick] ||
                (line_stamp[base+w] == line_stamp[base+pick] &&
                 line_rank[base+w] < line_rank[base+pick]))
              pick = w;
        end
      end
      line_valid[base+pick] = 1'b1;
      line_tag[base+pick]   = tg;
      line_stamp[base+pick] = set_ctr[set_no];
      set_ctr[set_no]++;
      make_recent(base, pick);
    end
    if (wr == MODE_WRITE) n_write++;
    res.mem_read    = !res.hit;
    res.mem_write   = (wr == MODE_WRITE);
    res.hit_total   = n_hit;
    res.miss_total  = n_miss;
    res.read_total  = n_read;
    res.write_total = n_write;
    return res;
  endfunction

  // build an address for a given tag and set under the current split
  function automatic logic [ADDR_W-1:0] compose_addr(logic [ADDR_W-1:0] tg,
                                                     int unsigned set_no);
    int unsigned       ib;
    logic [63:0]       noise;
    logic [ADDR_W-1:0] low;
    ib    = eff_index_bits();
    noise = {$urandom, $urandom};
    low   = noise[ADDR_W-1:0] & ((ADDR_W'(1) << cur_offset) - 1);
    return (tg << (cur_offset + ib)) | (ADDR_W'(set_no) << cur_offset) | low;
  endfunction

  // mostly a small hot working set so that hits and evictions are common
  function automatic logic [ADDR_W-1:0] random_address();
    int unsigned       ib, top_set, kind, set_no;
    logic [63:0]       raw;
    logic [ADDR_W-1:0] tg;
    ib      = eff_index_bits();
    top_set = (1 << ib) - 1;
    kind    = $urandom_range(0, 99);
    raw     = {$urandom, $urandom};
    if (kind < 10) return raw[ADDR_W-1:0];   // anywhere in the space
    set_no = (kind < 70) ? $urandom_range(0, (top_set > 3) ? 3 : top_set)
                         : $urandom_range(0, top_set);
    tg     = (kind < 85) ? ADDR_W'($urandom_range(0, 5)) : ADDR_W'($urandom_range(0, 15));
    return compose_addr(tg, set_no);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // offer one access word and wait for it to be taken
  task automatic send_access(logic wr, logic [ADDR_W-1:0] addr);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= wr;
    in_ch.address <= addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_q.push_back(lookup_access(wr, addr));
  endtask

  task automatic send_random(int count);
    int i;
    for (i = 0; i < count; i++)
      send_access($urandom_range(0, 1) ? MODE_WRITE : MODE_READ, random_address());
  endtask

  // stop sending and let every outstanding result word come back
  task automatic drain_lookups();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all three registers back to back; block must be idle
  task automatic apply_config(logic pol, logic [OFFSET_W-1:0] off, logic [INDEX_W-1:0] idx);
    logic [CFG_IDX_W-1:0]  regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    int i;
    regs = '{CFG_POLICY, CFG_OFFSET, CFG_INDEX};
    vals = '{CFG_DATA_W'(pol), CFG_DATA_W'(off), CFG_DATA_W'(idx)};
    drain_lookups();
    for (i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (regs[i])
        CFG_POLICY: cur_policy = vals[i][0];
        CFG_OFFSET: cur_offset = vals[i][OFFSET_W-1:0];
        CFG_INDEX:  cur_index  = vals[i][INDEX_W-1:0];
        default:    ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
    phase_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall density changes per stretch; long hold-offs on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(32, 256);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;    // no stalls at all
          1:       stall_pct = 15;
          2:       stall_pct = 40;
          default: stall_pct = 70;
        endcase
      end else begin
        phase_left--;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: every accepted word against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic note_failure(string what, bit have_want);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] %s", $realtime, what);
      if (have_want)
        $display("  expected hit=%0b rd=%0b wr=%0b totals h/m/r/w=%0d/%0d/%0d/%0d",
                 want_word.hit, want_word.mem_read, want_word.mem_write,
                 want_word.hit_total, want_word.miss_total,
                 want_word.read_total, want_word.write_total);
      $display("  actual   hit=%0b rd=%0b wr=%0b totals h/m/r/w=%0d/%0d/%0d/%0d",
               seen_word.hit, seen_word.mem_read, seen_word.mem_write,
               seen_word.hit_total, seen_word.miss_total,
               seen_word.read_total, seen_word.write_total);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_word.hit         = out_ch.hit;
      seen_word.mem_read    = out_ch.mem_read;
      seen_word.mem_write   = out_ch.mem_write;
      seen_word.hit_total   = out_ch.hit_total;
      seen_word.miss_total  = out_ch.miss_total;
      seen_word.read_total  = out_ch.read_total;
      seen_word.write_total = out_ch.write_total;
      if (pending_q.size() == 0) begin
        note_failure("result word with nothing expected", 1'b0);
      end else begin
        want_word = pending_q.pop_front();
        if (seen_word.hit !== want_word.hit ||
            seen_word.mem_read !== want_word.mem_read ||
            seen_word.mem_write !== want_word.mem_write ||
            seen_word.hit_total !== want_word.hit_total ||
            seen_word.miss_total !== want_word.miss_total ||
            seen_word.read_total !== want_word.read_total ||
            seen_word.write_total !== want_word.write_total)
          note_failure("result word mismatch", 1'b1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset defaults (LRU, 64-byte lines, 64 sets): extremes, vacancy, LRU victim
  task automatic test_lru_directed();
    int unsigned t;
    send_access(MODE_READ,  '0);                 // cold miss, vacant fill
    send_access(MODE_WRITE, '0);                 // hit, write through
    send_access(MODE_READ,  {ADDR_W{1'b1}});     // top set, all-ones tag
    send_access(MODE_WRITE, {ADDR_W{1'b1}});
    for (t = 1; t <= 4; t++)                     // fill set 5
      send_access(MODE_READ, compose_addr(ADDR_W'(t), 5));
    send_access(MODE_WRITE, compose_addr(ADDR_W'(1), 5));   // tag 1 most recent
    send_access(MODE_READ,  compose_addr(ADDR_W'(5), 5));   // evicts tag 2
    send_access(MODE_READ,  compose_addr(ADDR_W'(2), 5));   // miss, evicts tag 3
    send_access(MODE_READ,  compose_addr(ADDR_W'(1), 5));   // still a hit
  endtask

  // FIFO victim ignores hits; offset 0 with index past the clamp; index 0
  task automatic test_fifo_and_split_extremes();
    int unsigned t;
    apply_config(POLICY_FIFO, 4'd0, 3'd7);
    for (t = 10; t <= 13; t++)
      send_access(MODE_WRITE, compose_addr(ADDR_W'(t), 9));
    send_access(MODE_READ, compose_addr(ADDR_W'(10), 9));   // hit, no effect on order
    send_access(MODE_READ, compose_addr(ADDR_W'(14), 9));   // first in goes: tag 10
    send_access(MODE_READ, compose_addr(ADDR_W'(10), 9));   // miss again
    apply_config(POLICY_LRU, 4'd12, 3'd0);       // one set, 4 KiB lines
    send_access(MODE_READ,  compose_addr(ADDR_W'(3), 0));
    send_access(MODE_WRITE, compose_addr(ADDR_W'(3), 0));
  endtask

  // random traffic over a spread of policies and address splits
  task automatic test_policy_sweep();
    logic                pols [7];
    logic [OFFSET_W-1:0] offs [7];
    logic [INDEX_W-1:0]  idxs [7];
    int p;
    pols = '{POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO,
             POLICY_LRU, POLICY_FIFO, POLICY_LRU};
    offs = '{4'd6, 4'd6, 4'd0, 4'd15, 4'd12, 4'd0, 4'd3};
    idxs = '{3'd6, 3'd6, 3'd0, 3'd7, 3'd3, 3'd6, 3'd1};
    for (p = 0; p < 8; p++) begin
      if (p < 7)
        apply_config(pols[p], offs[p], idxs[p]);
      else
        apply_config($urandom_range(0, 1) ? POLICY_FIFO : POLICY_LRU,
                     OFFSET_W'($urandom_range(0, 15)), INDEX_W'($urandom_range(0, 7)));
      gaps_on = ($urandom_range(0, 3) != 0);   // some phases run back to back
      send_random(170);
    end
    gaps_on = 1'b1;
  endtask

  // output held off for a long stretch while input keeps coming
  task automatic test_backpressure();
    apply_config(POLICY_LRU, 4'd6, 3'd2);
    gaps_on = 1'b0;
    hold_asked++;
    send_random(80);
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int guard;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = MODE_READ;
    in_ch.address = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_POLICY;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    clear_directory();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_lru_directed();
    test_fifo_and_split_extremes();
    test_policy_sweep();
    test_backpressure();

    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_q.size() != 0) begin
      fail_count++;
      $display("%0d result words never arrived", pending_q.size());
    end

    $display("Ran %0d accesses (%0d hits, %0d misses, %0d writes) in %0d settings,",
             n_hit + n_miss, n_hit, n_miss, n_write, phase_count + 1);
    $display("LRU and FIFO, offset/index extremes, and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Timed out with %0d result words outstanding", pending_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule
